### hdl/tlkc_pkg.sv
// ----------------------------------------------------------------------------
// tlkc_pkg
// Shared types, codes and character helpers for the token lexer with keyword
// table: payload structs, controller commands and datapath status.
// ----------------------------------------------------------------------------
package tlkc_pkg;

  localparam int unsigned KEYWORD_SLOTS_DEFAULT = 64;
  localparam int unsigned TOKEN_CHARS_DEFAULT   = 32;

  localparam logic [1:0] OP_KW_CHAR  = 2'd0;
  localparam logic [1:0] OP_KW_END   = 2'd1;
  localparam logic [1:0] OP_SRC_BYTE = 2'd2;
  localparam logic [1:0] OP_SRC_END  = 2'd3;

  localparam logic [2:0] CLS_KEYWORD  = 3'd0;
  localparam logic [2:0] CLS_IDENT    = 3'd1;
  localparam logic [2:0] CLS_NUMBER   = 3'd2;
  localparam logic [2:0] CLS_OPERATOR = 3'd3;
  localparam logic [2:0] CLS_UNKNOWN  = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  token_class;
    logic [4:0]  token_length;
    logic [15:0] token_number;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic exec;
    logic load_word_tok;
    logic load_sym_tok;
    logic slot_clr;
    logic slot_inc;
    logic k_clr;
    logic k_inc;
    logic set_keyword;
    logic set_fallback;
    logic emit;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       word_char;
    logic       space;
    logic       word_nonempty;
    logic       slot_valid;
    logic       at_end;
    logic       end_ok;
    logic       char_ok;
    logic       out_free;
  } stat_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == 8'h5F;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return c == 8'h2B || c == 8'h2D || c == 8'h3D || c == 8'h2A ||
           c == 8'h2F || c == 8'h28 || c == 8'h29 || c == 8'h2C;
  endfunction

  function automatic logic [2:0] fallback_class(input logic [7:0] first,
                                                input logic       single);
    logic [2:0] cls;
    if (is_alpha(first) || first == 8'h5F) begin
      cls = CLS_IDENT;
    end else if (is_digit(first)) begin
      cls = CLS_NUMBER;
    end else if (single && is_operator(first)) begin
      cls = CLS_OPERATOR;
    end else begin
      cls = CLS_UNKNOWN;
    end
    return cls;
  endfunction

endpackage

### hdl/tlkc_ctrl.sv
// ----------------------------------------------------------------------------
// tlkc_ctrl
// Controller: accepts items, runs the per-item update, sequences the keyword
// table scan for each token and hands finished tokens to the output register.
// ----------------------------------------------------------------------------
module tlkc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           src_valid,
  output logic           src_ready,
  input  tlkc_pkg::stat_t st,
  output tlkc_pkg::cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       sym_pending;
  logic       sym_pending_next;

  assign src_ready = (state == ST_IDLE);

  always_comb begin
    cmd              = '0;
    state_next       = state;
    sym_pending_next = sym_pending;
    unique case (state)
      ST_IDLE: begin
        if (src_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec     = 1'b1;
        cmd.slot_clr = 1'b1;
        cmd.k_clr    = 1'b1;
        state_next   = ST_IDLE;
        unique case (st.op)
          tlkc_pkg::OP_SRC_BYTE: begin
            if (!st.word_char) begin
              if (st.word_nonempty) begin
                cmd.load_word_tok = 1'b1;
                sym_pending_next  = !st.space;
                state_next        = ST_CMP;
              end else if (!st.space) begin
                cmd.load_sym_tok = 1'b1;
                sym_pending_next = 1'b0;
                state_next       = ST_CMP;
              end
            end
          end
          tlkc_pkg::OP_SRC_END: begin
            if (st.word_nonempty) begin
              cmd.load_word_tok = 1'b1;
              sym_pending_next  = 1'b0;
              state_next        = ST_CMP;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_CMP: begin
        if (!st.slot_valid) begin
          cmd.set_fallback = 1'b1;
          state_next       = ST_OUT;
        end else if (st.at_end && st.end_ok) begin
          cmd.set_keyword = 1'b1;
          state_next      = ST_OUT;
        end else if (!st.at_end && st.char_ok) begin
          cmd.k_inc = 1'b1;
        end else begin
          cmd.slot_inc = 1'b1;
          cmd.k_clr    = 1'b1;
        end
      end
      ST_OUT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = !sym_pending;
          if (sym_pending) begin
            cmd.load_sym_tok = 1'b1;
            cmd.slot_clr     = 1'b1;
            cmd.k_clr        = 1'b1;
            sym_pending_next = 1'b0;
            state_next       = ST_CMP;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      sym_pending <= 1'b0;
    end else begin
      state       <= state_next;
      sym_pending <= sym_pending_next;
    end
  end

endmodule

### hdl/tlkc_dp.sv
// ----------------------------------------------------------------------------
// tlkc_dp
// Datapath: keyword character and length memories, word buffer, scan
// counters, character compare, token classification and output register.
// ----------------------------------------------------------------------------
module tlkc_dp #(
  parameter int unsigned KEYWORD_SLOTS = tlkc_pkg::KEYWORD_SLOTS_DEFAULT,
  parameter int unsigned TOKEN_CHARS   = tlkc_pkg::TOKEN_CHARS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  input  logic                src_ready,
  input  tlkc_pkg::in_item_t  src_item,
  output logic                tok_valid,
  input  logic                tok_ready,
  output tlkc_pkg::out_item_t tok_item,
  input  tlkc_pkg::cmd_t      cmd,
  output tlkc_pkg::stat_t     st
);

  localparam int unsigned SLOT_AW  = (KEYWORD_SLOTS > 1) ? $clog2(KEYWORD_SLOTS) : 1;
  localparam int unsigned SLOT_CW  = $clog2(KEYWORD_SLOTS + 1);
  localparam int unsigned TC_AW    = $clog2(TOKEN_CHARS);
  localparam int unsigned FILL_W   = $clog2(TOKEN_CHARS + 1);
  localparam int unsigned KW_DEPTH = KEYWORD_SLOTS * TOKEN_CHARS;
  localparam int unsigned KW_AW    = $clog2(KW_DEPTH);

  logic [7:0]        kw_mem [KW_DEPTH];
  logic [FILL_W-1:0] len_mem [KEYWORD_SLOTS];
  logic [7:0]        word_mem [TOKEN_CHARS];

  tlkc_pkg::in_item_t item;

  logic [SLOT_CW-1:0] held;
  logic [FILL_W-1:0]  fill;
  logic [TC_AW-1:0]   word_length;
  logic [7:0]         word_first;
  logic [15:0]        token_counter;

  logic [SLOT_CW-1:0] slot;
  logic [SLOT_CW-1:0] slot_next;
  logic [TC_AW-1:0]   k;
  logic [TC_AW-1:0]   k_next;

  logic               tok_sym;
  logic [TC_AW-1:0]   tok_len;
  logic [7:0]         tok_first;
  logic [2:0]         cls;

  logic [7:0]         kw_q;
  logic [FILL_W-1:0]  len_q;
  logic [7:0]         word_q;

  logic [KW_AW-1:0]   kw_raddr;
  logic [KW_AW-1:0]   kw_waddr;
  logic [TC_AW:0]     word_length_inc;
  logic [7:0]         tok_ch;
  logic               held_room;
  logic               fill_room;
  logic               word_char;

  assign held_room       = held < SLOT_CW'(KEYWORD_SLOTS);
  assign fill_room       = fill < FILL_W'(TOKEN_CHARS);
  assign word_char       = tlkc_pkg::is_word_char(item.char_byte);
  assign word_length_inc = {1'b0, word_length} + 1'b1;

  assign slot_next = cmd.slot_clr ? '0 : (cmd.slot_inc ? slot + 1'b1 : slot);
  assign k_next    = cmd.k_clr ? '0 : (cmd.k_inc ? k + 1'b1 : k);

  assign kw_raddr = KW_AW'(slot_next[SLOT_AW-1:0]) * KW_AW'(TOKEN_CHARS) + KW_AW'(k_next);
  assign kw_waddr = KW_AW'(held[SLOT_AW-1:0]) * KW_AW'(TOKEN_CHARS)
                  + KW_AW'(fill[TC_AW-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.exec && item.opcode == tlkc_pkg::OP_KW_CHAR && held_room && fill_room) begin
      kw_mem[kw_waddr] <= item.char_byte;
    end
    kw_q <= kw_mem[kw_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && item.opcode == tlkc_pkg::OP_KW_END && held_room) begin
      len_mem[held[SLOT_AW-1:0]] <= fill;
    end
    len_q <= len_mem[slot_next[SLOT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && item.opcode == tlkc_pkg::OP_SRC_BYTE && word_char) begin
      word_mem[word_length] <= item.char_byte;
    end
    word_q <= word_mem[k_next];
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      item <= src_item;
    end
    slot <= slot_next;
    k    <= k_next;
    if (cmd.exec && item.opcode == tlkc_pkg::OP_SRC_BYTE && word_char &&
        word_length == '0) begin
      word_first <= item.char_byte;
    end
    if (cmd.load_word_tok) begin
      tok_sym   <= 1'b0;
      tok_len   <= word_length;
      tok_first <= word_first;
    end else if (cmd.load_sym_tok) begin
      tok_sym   <= 1'b1;
      tok_len   <= TC_AW'(1);
      tok_first <= item.char_byte;
    end
    if (cmd.set_keyword) begin
      cls <= tlkc_pkg::CLS_KEYWORD;
    end else if (cmd.set_fallback) begin
      cls <= tlkc_pkg::fallback_class(tok_first, tok_len == TC_AW'(1));
    end
    if (cmd.emit) begin
      tok_item.token_class  <= cls;
      tok_item.token_length <= 5'(tok_len);
      tok_item.token_number <= token_counter;
      tok_item.last_of_run  <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held          <= '0;
      fill          <= '0;
      word_length   <= '0;
      token_counter <= '0;
      tok_valid     <= 1'b0;
    end else begin
      if (cmd.exec) begin
        unique case (item.opcode)
          tlkc_pkg::OP_KW_CHAR: begin
            if (held_room && fill_room) begin
              fill <= fill + 1'b1;
            end
          end
          tlkc_pkg::OP_KW_END: begin
            if (held_room) begin
              held <= held + 1'b1;
            end
            fill <= '0;
          end
          tlkc_pkg::OP_SRC_BYTE: begin
            if (word_char) begin
              if (word_length_inc >= (TC_AW + 1)'(TOKEN_CHARS - 1)) begin
                word_length <= '0;
              end else begin
                word_length <= word_length_inc[TC_AW-1:0];
              end
            end else begin
              word_length <= '0;
            end
          end
          tlkc_pkg::OP_SRC_END: begin
            word_length <= '0;
          end
          default: begin
            word_length <= word_length;
          end
        endcase
      end
      if (cmd.emit) begin
        token_counter <= token_counter + 1'b1;
        tok_valid     <= 1'b1;
      end else if (tok_ready) begin
        tok_valid <= 1'b0;
      end
    end
  end

  assign tok_ch = tok_sym ? tok_first : word_q;

  always_comb begin
    st               = '0;
    st.op            = item.opcode;
    st.word_char     = word_char;
    st.space         = tlkc_pkg::is_space(item.char_byte);
    st.word_nonempty = word_length != '0;
    st.slot_valid    = slot < held;
    st.at_end        = k == tok_len;
    st.end_ok        = (len_q == FILL_W'(tok_len)) || (kw_q == 8'h00);
    st.char_ok       = (len_q > FILL_W'(k)) && (kw_q != 8'h00) &&
                       (tlkc_pkg::to_lower(kw_q) == tlkc_pkg::to_lower(tok_ch));
    st.out_free      = !tok_valid || tok_ready;
  end

endmodule

### hdl/token_lexer_keyword_classifier_unit.sv
// ----------------------------------------------------------------------------
// token_lexer_keyword_classifier_unit
// Lexer that builds a keyword table from keyword characters and splits source
// bytes into classified tokens, reporting class, length and sequence number.
// ----------------------------------------------------------------------------
// One item is taken at a time. Each token passes through the keyword table
// scan and then the output register. The scan reads one character per cycle
// from the keyword memory and moves on to the next held keyword as soon as a
// character differs or the keyword is empty. A hit ends the scan at once;
// without a hit the scan settles the class once every held keyword has been
// tried. A token also waits while the output register holds an earlier token
// that has not been transferred. The output register lets the next item
// enter while the last token waits for transfer.
module token_lexer_keyword_classifier_unit #(
  parameter int unsigned KEYWORD_SLOTS = tlkc_pkg::KEYWORD_SLOTS_DEFAULT,
  parameter int unsigned TOKEN_CHARS   = tlkc_pkg::TOKEN_CHARS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_ready,
  input  tlkc_pkg::in_item_t  src_item,
  output logic                tok_valid,
  input  logic                tok_ready,
  output tlkc_pkg::out_item_t tok_item
);

  tlkc_pkg::cmd_t  cmd;
  tlkc_pkg::stat_t st;

  tlkc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .st        (st),
    .cmd       (cmd)
  );

  tlkc_dp #(
    .KEYWORD_SLOTS (KEYWORD_SLOTS),
    .TOKEN_CHARS   (TOKEN_CHARS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_item  (tok_item),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
